/* rtl/rps_pkg.sv */
// shared types and constants of the rtp payload splitter
// no dependencies; imported by every module of the block

package rps_pkg;

	localparam int MAX_PACKETS_DEF = 64;
	localparam int QUEUE_DEPTH     = 2;
	localparam int DIV_W           = 18;

	localparam int PAY_W   = 16;
	localparam int OVH_W   = 10;
	localparam int IDX_W   = 6;
	localparam int CNT17_W = 17;

	localparam logic [PAY_W-1:0] CAP_RESET = 16'd1200;

	typedef enum logic [1:0] {
		REG_MAX_PAYLOAD = 2'd0,
		REG_FIRST_OVH   = 2'd1,
		REG_LAST_OVH    = 2'd2,
		REG_SINGLE_OVH  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_ROOM = 2'd1,
		STATUS_MANY = 2'd2
	} split_status_t;

	typedef enum logic [1:0] {
		KIND_SINGLE = 2'd0,
		KIND_ROOM   = 2'd1,
		KIND_SPLIT  = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t           kind;
		logic [PAY_W-1:0]     payload;
		logic [CNT17_W-1:0]   per;
		logic [CNT17_W-1:0]   larger;
		logic [CNT17_W-1:0]   left;
	} split_item_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		F_IDLE  = 3'd0,
		F_CLASS = 3'd1,
		F_DIV1  = 3'd2,
		F_DIV2  = 3'd3,
		F_PUSH  = 3'd4
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE  = 2'd0,
		B_ONE   = 2'd1,
		B_COUNT = 2'd2,
		B_EMIT  = 2'd3
	} back_state_t;

endpackage

/* rtl/rps_div.sv */
// restoring divider, one quotient bit per cycle
// depends on rps_pkg

module rps_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rps_pkg::div_req_t req,
	output rps_pkg::div_rsp_t rsp
);
	import rps_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dq_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             qbit;
	logic [DIV_W-1:0] rem_nx;

	always_comb begin
		shifted = {rem_q, dq_q[DIV_W-1]};
		diff    = shifted - {1'b0, dsr_q};
		qbit    = shifted >= {1'b0, dsr_q};
		rem_nx  = qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dq_q  <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dq_q  <= {dq_q[DIV_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dq_q;
	assign rsp.rem  = rem_q;

endmodule

/* rtl/rps_front.sv */
// front end: takes a payload size, classifies it and works out the split plan
// depends on rps_pkg and rps_div

module rps_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [rps_pkg::PAY_W-1:0] in_payload,
	input  logic [rps_pkg::PAY_W-1:0] cap,
	input  logic [rps_pkg::OVH_W-1:0] first_ovh,
	input  logic [rps_pkg::OVH_W-1:0] last_ovh,
	input  logic [rps_pkg::OVH_W-1:0] single_ovh,
	output logic                      push,
	output rps_pkg::split_item_t      push_item,
	input  logic                      full
);
	import rps_pkg::*;

	front_state_t         state_q, state_d;
	logic [PAY_W-1:0]     payload_q;
	item_kind_t           kind_q, kind_d;
	logic [CNT17_W-1:0]   left_q, per_q, larger_q;
	logic [CNT17_W-1:0]   left_n;
	logic [DIV_W-1:0]     tot;
	logic                 fits;
	div_req_t             dreq;
	div_rsp_t             drsp;

	rps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		tot    = DIV_W'(payload_q) + DIV_W'(first_ovh) + DIV_W'(last_ovh);
		fits   = {1'b0, cap} >= ({1'b0, payload_q} + (PAY_W+1)'(single_ovh));
		left_n = (drsp.quot[CNT17_W-1:0] == CNT17_W'(1)) ? CNT17_W'(2)
			: drsp.quot[CNT17_W-1:0];
		if (payload_q == '0) begin
			kind_d = KIND_ROOM;
		end else if (fits) begin
			kind_d = KIND_SINGLE;
		end else if (cap <= PAY_W'(first_ovh) || cap <= PAY_W'(last_ovh)) begin
			kind_d = KIND_ROOM;
		end else begin
			kind_d = KIND_SPLIT;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		push          = 1'b0;
		dreq.start    = 1'b0;
		dreq.dividend = tot + DIV_W'(cap) - DIV_W'(1);
		dreq.divisor  = DIV_W'(cap);
		case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = F_CLASS;
			end
			F_CLASS: begin
				if (kind_d == KIND_SPLIT) begin
					dreq.start = 1'b1;
					state_d    = F_DIV1;
				end else begin
					state_d = F_PUSH;
				end
			end
			F_DIV1: begin
				dreq.dividend = tot;
				dreq.divisor  = DIV_W'(left_n);
				if (drsp.done) begin
					dreq.start = 1'b1;
					state_d    = F_DIV2;
				end
			end
			F_DIV2: begin
				if (drsp.done) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) payload_q <= in_payload;
		if (state_q == F_CLASS) kind_q <= kind_d;
		if (state_q == F_DIV1 && drsp.done) left_q <= left_n;
		if (state_q == F_DIV2 && drsp.done) begin
			per_q    <= drsp.quot[CNT17_W-1:0];
			larger_q <= drsp.rem[CNT17_W-1:0];
		end
	end

	assign push_item.kind    = kind_q;
	assign push_item.payload = payload_q;
	assign push_item.per     = per_q;
	assign push_item.larger  = larger_q;
	assign push_item.left    = left_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == F_DIV1 || state_q == F_DIV2))
		else $error("divider finished outside a division state");

endmodule

/* rtl/rps_fifo.sv */
// short queue of split plans between front and back
// depends on rps_pkg

module rps_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rps_pkg::split_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output rps_pkg::split_item_t head,
	output logic                 empty
);
	import rps_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	split_item_t       mem [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [NW-1:0]     num_q;

	function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
		if (p == PW'(QUEUE_DEPTH - 1)) return '0;
		return p + PW'(1);
	endfunction

	assign full  = num_q == NW'(QUEUE_DEPTH);
	assign empty = num_q == '0;
	assign head  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			num_q <= '0;
		end else begin
			if (push) wr_q <= inc_ptr(wr_q);
			if (pop)  rd_q <= inc_ptr(rd_q);
			if (push && !pop) num_q <= num_q + NW'(1);
			else if (pop && !push) num_q <= num_q - NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_item;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

/* rtl/rps_back.sv */
// back end: walks the split plan, checks the packet count, then emits packet sizes
// depends on rps_pkg; drives the output register

module rps_back #(
	parameter int MAX_PACKETS = rps_pkg::MAX_PACKETS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [rps_pkg::OVH_W-1:0] first_ovh,
	input  rps_pkg::split_item_t      head,
	input  logic                      empty,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [rps_pkg::PAY_W-1:0] out_bytes,
	output logic [rps_pkg::IDX_W-1:0] out_index,
	output logic                      out_last,
	output rps_pkg::split_status_t    out_status
);
	import rps_pkg::*;

	localparam int CW = $clog2(MAX_PACKETS + 1);

	back_state_t          state_q, state_d;
	split_item_t          ent_q;
	logic [PAY_W-1:0]     remain_q;
	logic signed [17:0]   lft_q;
	logic [CNT17_W-1:0]   per_q;
	logic                 isfirst_q;
	logic [CW-1:0]        cnt_q;
	logic [PAY_W-1:0]     res_bytes_q;
	split_status_t        res_status_q;

	logic                 ov_q;
	logic [PAY_W-1:0]     ob_q;
	logic [IDX_W-1:0]     oi_q;
	logic                 ol_q;
	split_status_t        os_q;

	logic [CNT17_W-1:0]   per_n;
	logic [CNT17_W-1:0]   cur_a;
	logic [PAY_W-1:0]     cur_b, cur;
	logic                 slot_free;

	logic                 init_en, step_en, cnt_clr, cnt_inc, res_en, out_load;
	logic [PAY_W-1:0]     res_bytes_d, ld_bytes;
	split_status_t        res_status_d, ld_status;
	logic [IDX_W-1:0]     ld_index;
	logic                 ld_last;

	assign slot_free = !ov_q || out_ready;

	// one step of the packet plan
	always_comb begin
		per_n = (lft_q == $signed({1'b0, ent_q.larger})) ? per_q + CNT17_W'(1) : per_q;
		cur_a = per_n;
		if (isfirst_q) begin
			if (per_n > CNT17_W'(first_ovh) + CNT17_W'(1)) cur_a = per_n - CNT17_W'(first_ovh);
			else cur_a = CNT17_W'(1);
		end
		cur_b = (cur_a > CNT17_W'(remain_q)) ? remain_q : cur_a[PAY_W-1:0];
		cur   = (lft_q == 18'sd2 && cur_b == remain_q) ? cur_b - PAY_W'(1) : cur_b;
	end

	always_comb begin
		state_d      = state_q;
		pop          = 1'b0;
		init_en      = 1'b0;
		step_en      = 1'b0;
		cnt_clr      = 1'b0;
		cnt_inc      = 1'b0;
		res_en       = 1'b0;
		res_bytes_d  = '0;
		res_status_d = STATUS_ROOM;
		out_load     = 1'b0;
		ld_bytes     = res_bytes_q;
		ld_index     = '0;
		ld_last      = 1'b1;
		ld_status    = res_status_q;
		case (state_q)
			B_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (head.kind)
						KIND_SINGLE: begin
							res_en       = 1'b1;
							res_bytes_d  = head.payload;
							res_status_d = STATUS_OK;
							state_d      = B_ONE;
						end
						KIND_SPLIT: begin
							init_en = 1'b1;
							cnt_clr = 1'b1;
							state_d = B_COUNT;
						end
						default: begin
							res_en  = 1'b1;
							state_d = B_ONE;
						end
					endcase
				end
			end
			B_COUNT: begin
				if (remain_q == '0) begin
					init_en = 1'b1;
					cnt_clr = 1'b1;
					state_d = B_EMIT;
				end else if (cnt_q >= CW'(MAX_PACKETS)) begin
					res_en       = 1'b1;
					res_status_d = STATUS_MANY;
					state_d      = B_ONE;
				end else begin
					step_en = 1'b1;
					cnt_inc = 1'b1;
				end
			end
			B_EMIT: begin
				if (slot_free) begin
					out_load  = 1'b1;
					ld_bytes  = cur;
					ld_index  = IDX_W'(cnt_q);
					ld_last   = cur == remain_q;
					ld_status = STATUS_OK;
					step_en   = 1'b1;
					cnt_inc   = 1'b1;
					if (cur == remain_q) state_d = B_IDLE;
				end
			end
			B_ONE: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= head;
		if (res_en) begin
			res_bytes_q  <= res_bytes_d;
			res_status_q <= res_status_d;
		end
		if (init_en) begin
			remain_q  <= (state_q == B_IDLE) ? head.payload : ent_q.payload;
			lft_q     <= (state_q == B_IDLE) ? $signed({1'b0, head.left})
				: $signed({1'b0, ent_q.left});
			per_q     <= (state_q == B_IDLE) ? head.per : ent_q.per;
			isfirst_q <= 1'b1;
		end else if (step_en) begin
			remain_q  <= remain_q - cur;
			lft_q     <= lft_q - 18'sd1;
			per_q     <= per_n;
			isfirst_q <= 1'b0;
		end
		if (cnt_clr) cnt_q <= '0;
		else if (cnt_inc) cnt_q <= cnt_q + CW'(1);
		if (out_load) begin
			ob_q <= ld_bytes;
			oi_q <= ld_index;
			ol_q <= ld_last;
			os_q <= ld_status;
		end
	end

	assign out_valid  = ov_q;
	assign out_bytes  = ob_q;
	assign out_index  = oi_q;
	assign out_last   = ol_q;
	assign out_status = os_q;

	a_error_word_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && os_q != STATUS_OK) |-> (ol_q && ob_q == '0 && oi_q == '0))
		else $error("error word is not a single empty packet");
	a_emit_has_bytes_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT) |-> (remain_q != '0))
		else $error("emitting with nothing left to split");

endmodule

/* rtl/rtp_payload_split_about_equal_unit.sv */
// top level of the rtp payload splitter: configuration registers, front, queue, back
// depends on rps_pkg, rps_front, rps_fifo, rps_back
//
// usage:
//   configuration: wr_en writes wr_data into register wr_index (0 max payload,
//   1 first overhead, 2 last overhead, 3 single overhead); write only while idle.
//   input stream: one word per payload, s_axis_tdata holds the payload size.
//   output stream: one word per packet; tlast marks the final word of a payload,
//   tuser carries the status, an error gives a single word of zero bytes.
//   front end: an empty, single-packet or no-room payload passes the classify and
//   push states into the queue after it is taken; a split also needs two divider
//   passes, one for the packet count and one for the per-packet size.
//   the back end then runs a count pass over the planned packets (at most
//   MAX_PACKETS of them) before it emits one word per packet. the divider and
//   the count pass set the rate.
//   front and back run independently through a two-entry queue, so a new payload
//   is taken while the previous one is still being emitted.
//   reset: registers return to 1200/0/0/0 and all streams are empty.
//   a stalled receiver holds the output word; the back end and then the queue
//   fill and s_axis_tready drops.

module rtp_payload_split_about_equal_unit #(
	parameter int MAX_PACKETS = rps_pkg::MAX_PACKETS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  rps_pkg::cfg_reg_t         wr_index,
	input  logic [rps_pkg::PAY_W-1:0] wr_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [15:0]               s_axis_tdata,  // payload_bytes
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [23:0]               m_axis_tdata,  // packet_bytes, packet_index, zero pad
	output logic                      m_axis_tlast,  // last_packet
	output logic [1:0]                m_axis_tuser   // split_status
);
	import rps_pkg::*;

	logic [PAY_W-1:0] cap_q;
	logic [OVH_W-1:0] first_q, last_q, single_q;

	logic             push, pop, full, empty;
	split_item_t      push_item, head;

	logic [PAY_W-1:0] out_bytes;
	logic [IDX_W-1:0] out_index;
	split_status_t    out_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			first_q  <= '0;
			last_q   <= '0;
			single_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAX_PAYLOAD: cap_q    <= wr_data;
				REG_FIRST_OVH:   first_q  <= wr_data[OVH_W-1:0];
				REG_LAST_OVH:    last_q   <= wr_data[OVH_W-1:0];
				REG_SINGLE_OVH:  single_q <= wr_data[OVH_W-1:0];
				default: ;
			endcase
		end
	end

	rps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_payload (s_axis_tdata),
		.cap        (cap_q),
		.first_ovh  (first_q),
		.last_ovh   (last_q),
		.single_ovh (single_q),
		.push       (push),
		.push_item  (push_item),
		.full       (full)
	);

	rps_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	rps_back #(
		.MAX_PACKETS (MAX_PACKETS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.first_ovh  (first_q),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_bytes  (out_bytes),
		.out_index  (out_index),
		.out_last   (m_axis_tlast),
		.out_status (out_status)
	);

	assign m_axis_tdata = {2'b00, out_index, out_bytes};
	assign m_axis_tuser = out_status;

endmodule

/* dv/rtp_payload_split_about_equal_unit_tb.sv */
// testbench of rtp_payload_split_about_equal_unit: directed and random payload sizes,
// several register settings and idle patterns, each packet word checked against a plan
// depends on rps_pkg and the rtl of the unit
`timescale 1ns / 1ps

module rtp_payload_split_about_equal_unit_tb;
	import rps_pkg::*;

	typedef struct {
		logic [15:0]   bytes;
		logic [5:0]    index;
		logic          last;
		split_status_t status;
	} packet_word_t;

	typedef struct {
		int cap;
		int first_ovh;
		int last_ovh;
		int single_ovh;
	} split_setting_t;

	class split_board;
		int cap;
		int first_ovh;
		int last_ovh;
		int single_ovh;
		packet_word_t pending_packets[$];
		int mismatches;

		function new();
			cap = int'(CAP_RESET);
			first_ovh = 0;
			last_ovh = 0;
			single_ovh = 0;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, int val);
			case (idx)
				REG_MAX_PAYLOAD: cap = val & 16'hFFFF;
				REG_FIRST_OVH:   first_ovh = val & 10'h3FF;
				REG_LAST_OVH:    last_ovh = val & 10'h3FF;
				REG_SINGLE_OVH:  single_ovh = val & 10'h3FF;
				default: ;
			endcase
		endfunction

		function void push_word(int bytes, int idx, bit last, split_status_t status);
			packet_word_t w;
			w.bytes = bytes[15:0];
			w.index = idx[5:0];
			w.last = last;
			w.status = status;
			pending_packets.insert(pending_packets.size(), w);
		endfunction

		// work out the packet sizes of one accepted payload
		function void plan_payload(logic [15:0] payload);
			int p;
			int total;
			int left;
			int per;
			int larger;
			int remain;
			int cur;
			bit first_pkt;
			int sizes[$];
			p = int'(payload);
			if (p == 0) begin
				push_word(0, 0, 1'b1, STATUS_ROOM);
				return;
			end
			if (cap >= p + single_ovh) begin
				push_word(p, 0, 1'b1, STATUS_OK);
				return;
			end
			if (cap <= first_ovh || cap <= last_ovh) begin
				push_word(0, 0, 1'b1, STATUS_ROOM);
				return;
			end
			total = p + first_ovh + last_ovh;
			left = (total + cap - 1) / cap;
			if (left == 1)
				left = 2;
			per = total / left;
			larger = total % left;
			remain = p;
			first_pkt = 1'b1;
			while (remain > 0) begin
				if (sizes.size() >= MAX_PACKETS_DEF) begin
					push_word(0, 0, 1'b1, STATUS_MANY);
					return;
				end
				if (left == larger)
					per++;
				cur = per;
				if (first_pkt)
					cur = (cur - first_ovh > 1) ? cur - first_ovh : 1;
				if (cur > remain)
					cur = remain;
				if (left == 2 && cur == remain)
					cur--;
				remain -= cur;
				left--;
				sizes.insert(sizes.size(), cur);
				first_pkt = 1'b0;
			end
			foreach (sizes[k])
				push_word(sizes[k], k, k == sizes.size() - 1, STATUS_OK);
		endfunction

		function void check_packet(packet_word_t got);
			packet_word_t want;
			if (pending_packets.size() == 0) begin
				$display("%0t unexpected word: expected none, got bytes %0d index %0d",
					$time, got.bytes, got.index);
				mismatches++;
				return;
			end
			want = pending_packets.pop_front();
			if (got.bytes !== want.bytes) begin
				$display("%0t packet_bytes: expected %0d, got %0d", $time, want.bytes, got.bytes);
				mismatches++;
			end
			if (got.index !== want.index) begin
				$display("%0t packet_index: expected %0d, got %0d", $time, want.index, got.index);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$display("%0t last_packet: expected %0d, got %0d", $time, want.last, got.last);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$display("%0t split_status: expected %0d, got %0d", $time, want.status,
					got.status);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	cfg_reg_t    wr_index;
	logic [15:0] wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // payload_bytes
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;   // packet_bytes, packet_index, zero pad
	logic        m_axis_tlast;   // last_packet
	logic [1:0]  m_axis_tuser;   // split_status

	split_board board;
	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;

	rtp_payload_split_about_equal_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (wr_en),
		.wr_index      (wr_index),
		.wr_data       (wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (stall_pct == 0)
			m_axis_tready <= 1'b1;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		packet_word_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				board.plan_payload(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				got.bytes = m_axis_tdata[15:0];
				got.index = m_axis_tdata[21:16];
				got.last = m_axis_tlast;
				got.status = split_status_t'(m_axis_tuser);
				board.check_packet(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic set_idle(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 70; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 70; end
			default: begin send_idle_pct = 29; stall_pct = 29; end
		endcase
	endtask

	task automatic send_payload(input int p);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p[15:0];
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic feed(input int sizes[$]);
		foreach (sizes[k])
			send_payload(sizes[k]);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain_packets();
		do @(posedge clk); while (board.pending_packets.size() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val[15:0];
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic apply_setting(input split_setting_t cfg);
		drain_packets();
		repeat (4) @(posedge clk);
		write_reg(REG_MAX_PAYLOAD, cfg.cap);
		write_reg(REG_FIRST_OVH, cfg.first_ovh);
		write_reg(REG_LAST_OVH, cfg.last_ovh);
		write_reg(REG_SINGLE_OVH, cfg.single_ovh);
		wr_en <= 1'b0;
	endtask

	function automatic int pick_overhead(int cap);
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 0;
		if (r < 75)
			return $urandom_range(0, (cap / 3 > 1023) ? 1023 : cap / 3);
		return $urandom_range(0, 1023);
	endfunction

	function automatic split_setting_t pick_setting();
		split_setting_t cfg;
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			cfg.cap = $urandom_range(50, 3000);
		else if (r < 90)
			cfg.cap = $urandom_range(1, 65535);
		else
			cfg.cap = $urandom_range(1, 20);
		cfg.first_ovh = pick_overhead(cfg.cap);
		cfg.last_ovh = pick_overhead(cfg.cap);
		cfg.single_ovh = pick_overhead(cfg.cap);
		return cfg;
	endfunction

	function automatic int draw_payload(int cap);
		int r;
		int lo;
		int hi;
		r = $urandom_range(0, 99);
		if (r < 3)
			return 0;
		if (r < 25) begin
			lo = 1;
			hi = cap;
		end else if (r < 40) begin
			lo = (cap > 4) ? cap - 3 : 1;
			hi = cap + 3;
		end else if (r < 85) begin
			lo = cap + 1;
			hi = cap * 8;
		end else if (r < 93) begin
			lo = 1;
			hi = 65535;
		end else begin
			lo = cap * 64 - 2;
			hi = cap * 64 + 2;
		end
		if (lo > 65535)
			lo = 65535;
		if (hi > 65535)
			hi = 65535;
		return $urandom_range(lo, hi);
	endfunction

	initial begin
		int sizes[$];
		split_setting_t cfg;
		board = new();
		send_idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_MAX_PAYLOAD;
		wr_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: empty, fits, just over, 55-packet split
		set_idle(0);
		sizes = '{0, 1, 1200, 1201, 2400, 65535};
		feed(sizes);

		// exactly 64 packets and one too many
		cfg = '{1023, 0, 0, 0};
		apply_setting(cfg);
		set_idle(1);
		sizes = '{65535, 65472, 1023, 1024};
		feed(sizes);

		// tiny split with a zero-byte first packet
		cfg = '{2, 1, 0, 5};
		apply_setting(cfg);
		set_idle(2);
		sizes = '{1, 2, 3};
		feed(sizes);

		// no room for the first overhead
		cfg = '{100, 1023, 5, 7};
		apply_setting(cfg);
		set_idle(3);
		sizes = '{93, 94, 0};
		feed(sizes);

		// widest registers
		cfg = '{65535, 1023, 1023, 1023};
		apply_setting(cfg);
		set_idle(0);
		sizes = '{65535, 64512, 64513};
		feed(sizes);

		// one-byte packets
		cfg = '{1, 0, 0, 0};
		apply_setting(cfg);
		set_idle(3);
		sizes = '{1, 2, 64, 65};
		feed(sizes);

		for (int ph = 0; ph < 8; ph++) begin
			cfg = pick_setting();
			apply_setting(cfg);
			set_idle(ph);
			for (int i = 0; i < 57; i++) begin
				send_payload(draw_payload(cfg.cap));
				if (ph == 0 && i == 20) begin
					s_axis_tvalid <= 1'b0;
					drain_packets();
				end
			end
			s_axis_tvalid <= 1'b0;
		end

		drain_packets();
		repeat (200) @(posedge clk);
		if (board.mismatches == 0 && board.pending_packets.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
